### src/tilted_projection_binner_core_assert.svh
// Assertion macros for the tilted projection binner.
// Expects clk_i and rst_ni in the scope of use.
`ifndef TILTED_PROJECTION_BINNER_CORE_ASSERT_SVH
`define TILTED_PROJECTION_BINNER_CORE_ASSERT_SVH

// same-cycle implication
`define TPB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tpb_pkg.sv
// Package for the tilted projection binner: field widths, codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package tpb_pkg;

  localparam int unsigned MaxRowsDef  = 1024;
  localparam int unsigned BinWidthDef = 40;
  localparam int unsigned QueueDepth  = 2;

  localparam int unsigned PixW     = 16;
  localparam int unsigned PosW     = 10;
  localparam int unsigned DimW     = 11;
  localparam int unsigned TiltW    = 16;
  localparam int unsigned OutValW  = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DeltaW   = PixW + 1;
  // bin address width covering the largest supported bin count
  localparam int unsigned CmdAddrW = 12;
  // common width for range compares
  localparam int unsigned CmpW     = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TILT   = 2'd0,
    CFG_DARK   = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_WIDTH  = 2'd3
  } tpb_cfg_idx_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_READ  = 1'b1
  } tpb_req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } tpb_state_e;

  typedef struct packed {
    logic                     is_read;
    logic                     hit;
    logic [PosW-1:0]          idx;
    logic [CmdAddrW-1:0]      addr;
    logic signed [DeltaW-1:0] delta;
  } tpb_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic updating;
  } tpb_stat_t;

endpackage

### src/tpb_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on tpb_pkg.
`timescale 1ns / 1ps
interface tpb_req_if;
  import tpb_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [PosW-1:0] pixel_row;
  logic [PosW-1:0] pixel_col;
  logic [PixW-1:0] pixel_value;
  logic [PixW-1:0] dark_value;
  logic [PosW-1:0] read_bin;
  modport source (output valid, req_type, pixel_row, pixel_col, pixel_value, dark_value,
                  read_bin, input ready);
  modport sink (input valid, req_type, pixel_row, pixel_col, pixel_value, dark_value,
                read_bin, output ready);
endinterface

interface tpb_res_if;
  import tpb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [PosW-1:0]           bin_index;
  logic signed [OutValW-1:0] bin_value;
  logic                      in_range;
  modport source (output valid, bin_index, bin_value, in_range, input ready);
  modport sink (input valid, bin_index, bin_value, in_range, output ready);
endinterface

interface tpb_cfg_if;
  import tpb_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/tpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tpb_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### src/tpb_fifo.sv
// Short command queue between the front and back ends.
// Depends on tpb_pkg.
`timescale 1ns / 1ps
module tpb_fifo #(
  parameter int unsigned DEPTH = tpb_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpb_pkg::tpb_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output tpb_pkg::tpb_cmd_t head_o,
  output logic              empty_o
);
  import tpb_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tpb_cmd_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule

### src/tpb_front.sv
// Front end: config registers, request intake, bin computation and range check.
// Depends on tpb_pkg and tpb_if.
`timescale 1ns / 1ps
module tpb_front #(
  parameter int unsigned MAX_ROWS = tpb_pkg::MaxRowsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tpb_req_if.sink           req_i,
  tpb_cfg_if.sink           cfg_i,
  input  tpb_pkg::tpb_stat_t stat_i,
  input  logic              q_full_i,
  output logic              push_o,
  output tpb_pkg::tpb_cmd_t cmd_o
);
  import tpb_pkg::*;

  logic signed [TiltW-1:0] tilt_q;
  logic                    dark_en_q;
  logic [DimW-1:0]         height_q;
  logic [DimW-1:0]         width_q;

  logic [CmpW-1:0]         rows;
  logic signed [26:0]      prod;
  logic signed [26:0]      prod_up;
  logic signed [14:0]      ceil_v;
  logic signed [16:0]      bin;
  logic                    pix_hit;
  logic                    rd_hit;
  logic signed [DeltaW-1:0] delta;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q    <= '0;
      dark_en_q <= 1'b0;
      height_q  <= DimW'(1024);
      width_q   <= DimW'(1024);
    end else if (cfg_i.valid) begin
      case (tpb_cfg_idx_e'(cfg_i.index))
        CFG_TILT:   tilt_q    <= cfg_i.data;
        CFG_DARK:   dark_en_q <= cfg_i.data[0];
        CFG_HEIGHT: height_q  <= cfg_i.data[DimW-1:0];
        CFG_WIDTH:  width_q   <= cfg_i.data[DimW-1:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = stat_i.clear_done && !q_full_i;
  assign push_o      = req_i.valid && req_i.ready;

  always_comb begin
    rows = ({5'b0, height_q} > CmpW'(MAX_ROWS)) ? CmpW'(MAX_ROWS) : {5'b0, height_q};
    // ceil(col * tan) with 12 fraction bits
    prod    = $signed({1'b0, req_i.pixel_col}) * tilt_q;
    prod_up = prod + 27'sd4095;
    ceil_v  = prod_up[26:12];
    bin     = $signed({7'b0, req_i.pixel_row}) + 17'(ceil_v);
    pix_hit = ({6'b0, req_i.pixel_row} < rows) && ({1'b0, req_i.pixel_col} < width_q) &&
              !bin[16] && (bin[15:0] < rows);
    rd_hit  = ({6'b0, req_i.read_bin} < rows);
    delta   = dark_en_q ? $signed({1'b0, req_i.pixel_value}) - $signed({1'b0, req_i.dark_value})
                        : $signed({1'b0, req_i.pixel_value});

    cmd_o.is_read = (tpb_req_e'(req_i.req_type) == REQ_READ);
    cmd_o.delta   = delta;
    if (cmd_o.is_read) begin
      cmd_o.hit  = rd_hit;
      cmd_o.idx  = req_i.read_bin;
      cmd_o.addr = {2'b0, req_i.read_bin};
    end else begin
      cmd_o.hit  = pix_hit;
      cmd_o.idx  = pix_hit ? bin[PosW-1:0] : '0;
      cmd_o.addr = bin[CmdAddrW-1:0];
    end
  end
endmodule

### src/tpb_back.sv
// Back end: bin store clearing pass, read-modify-write with saturation, result register.
// Depends on tpb_pkg and tpb_if.
`timescale 1ns / 1ps
module tpb_back #(
  parameter int unsigned MAX_ROWS  = tpb_pkg::MaxRowsDef,
  parameter int unsigned BIN_WIDTH = tpb_pkg::BinWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  tpb_pkg::tpb_cmd_t           head_i,
  output logic                        pop_o,
  output tpb_pkg::tpb_stat_t          stat_o,
  output logic                        ram_we_o,
  output logic [$clog2(MAX_ROWS)-1:0] ram_waddr_o,
  output logic [BIN_WIDTH-1:0]        ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(MAX_ROWS)-1:0] ram_raddr_o,
  input  logic [BIN_WIDTH-1:0]        ram_rdata_i,
  tpb_res_if.source                   res_o
);
  import tpb_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ROWS);

  tpb_state_e                 st_q, st_d;
  logic [AddrW-1:0]           clr_q, clr_d;
  tpb_cmd_t                   cur_q, cur_d;
  logic                       rvalid_q, rvalid_d;
  logic [PosW-1:0]            ridx_q, ridx_d;
  logic [OutValW-1:0]         rval_q, rval_d;
  logic                       rrng_q, rrng_d;

  logic                       out_free;
  logic signed [BIN_WIDTH:0]  sum;
  logic [BIN_WIDTH-1:0]       sat;
  logic [BIN_WIDTH-1:0]       new_v;
  logic [64:0]                ext_v;

  assign out_free = !rvalid_q || res_o.ready;

  always_comb begin
    sum = $signed({ram_rdata_i[BIN_WIDTH-1], ram_rdata_i}) +
          $signed({{(BIN_WIDTH + 1 - DeltaW){cur_q.delta[DeltaW-1]}}, cur_q.delta});
    if (sum[BIN_WIDTH] != sum[BIN_WIDTH-1]) begin
      sat = sum[BIN_WIDTH] ? {1'b1, {(BIN_WIDTH-1){1'b0}}} : {1'b0, {(BIN_WIDTH-1){1'b1}}};
    end else begin
      sat = sum[BIN_WIDTH-1:0];
    end
    new_v = cur_q.is_read ? ram_rdata_i : sat;
    ext_v = {{(65 - BIN_WIDTH){new_v[BIN_WIDTH-1]}}, new_v};
  end

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    rvalid_d    = rvalid_q;
    ridx_d      = ridx_q;
    rval_d      = rval_q;
    rrng_d      = rrng_q;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_q.addr[AddrW-1:0];
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_i.addr[AddrW-1:0];

    if (rvalid_q && res_o.ready) begin
      rvalid_d = 1'b0;
    end

    case (st_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == AddrW'(MAX_ROWS - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i && out_free) begin
          pop_o = 1'b1;
          if (head_i.hit) begin
            ram_re_o = 1'b1;
            cur_d    = head_i;
            st_d     = ST_UPDATE;
          end else begin
            rvalid_d = 1'b1;
            ridx_d   = head_i.idx;
            rval_d   = '0;
            rrng_d   = 1'b0;
          end
        end
      end
      ST_UPDATE: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = cur_q.is_read ? '0 : sat;
        rvalid_d    = 1'b1;
        ridx_d      = cur_q.idx;
        rval_d      = ext_v[OutValW-1:0];
        rrng_d      = 1'b1;
        st_d        = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      clr_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    ridx_q <= ridx_d;
    rval_q <= rval_d;
    rrng_q <= rrng_d;
  end

  assign stat_o.clear_done = (st_q != ST_CLEAR);
  assign stat_o.updating   = (st_q == ST_UPDATE);

  assign res_o.valid     = rvalid_q;
  assign res_o.bin_index = ridx_q;
  assign res_o.bin_value = rval_q;
  assign res_o.in_range  = rrng_q;
endmodule

### src/tilted_projection_binner_core.sv
// Top level of the tilted projection binner: front end, command queue, back end, bin RAM.
// Depends on tpb_pkg, tpb_if, tpb_ram, tpb_fifo, tpb_front, tpb_back and the assert header.
`timescale 1ns / 1ps
// Folds a streamed camera image into a spectrum: a pixel at (row, col) adds its value,
// less its dark value when enabled, to bin row + ceil(col * tan) with saturation; a read
// returns a bin and clears it. One result beat per request beat, in order. After reset the
// bin RAM is swept to zero, address by address, during which no request is taken;
// configuration writes are taken at any time. A request that hits a bin takes the back end
// through a RAM read, then a write-back through the single RAM write port, before the back
// end takes the next request; a miss is answered from the idle state. A two-entry queue lets
// requests enter while the back end or the result register waits.
module tilted_projection_binner_core #(
  parameter int unsigned MAX_ROWS  = tpb_pkg::MaxRowsDef,
  parameter int unsigned BIN_WIDTH = tpb_pkg::BinWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpb_req_if.sink   req_i,
  tpb_cfg_if.sink   cfg_i,
  tpb_res_if.source res_o
);
  import tpb_pkg::*;

  `include "tilted_projection_binner_core_assert.svh"

  localparam int unsigned AddrW = $clog2(MAX_ROWS);

  tpb_stat_t            stat;
  tpb_cmd_t             push_cmd;
  tpb_cmd_t             head_cmd;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  logic                 ram_we;
  logic                 ram_re;
  logic [AddrW-1:0]     ram_waddr;
  logic [AddrW-1:0]     ram_raddr;
  logic [BIN_WIDTH-1:0] ram_wdata;
  logic [BIN_WIDTH-1:0] ram_rdata;

  tpb_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cfg_i    (cfg_i),
    .stat_i   (stat),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  tpb_fifo #(
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty)
  );

  tpb_back #(
    .MAX_ROWS  (MAX_ROWS),
    .BIN_WIDTH (BIN_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .stat_o      (stat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_o       (res_o)
  );

  tpb_ram #(
    .WIDTH (BIN_WIDTH),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `TPB_ASSERT_IMPL(a_no_req_in_clear, req_i.valid && req_i.ready, stat.clear_done, "request beat taken during clearing pass")
  `TPB_ASSERT_IMPL(a_no_push_full, push, !q_full, "push into full queue")
  `TPB_ASSERT_IMPL(a_miss_zero, res_o.valid && !res_o.in_range, res_o.bin_value == '0, "miss result carries nonzero value")
  `TPB_ASSERT_NEXT(a_single_update, stat.updating, !stat.updating, "back end updated on two cycles in a row")
endmodule
